// ===== rtl/core/voxel_ray_traversal_macros.svh =====
// assertion macros for the voxel ray traversal block
`ifndef VOXEL_RAY_TRAVERSAL_MACROS_SVH
`define VOXEL_RAY_TRAVERSAL_MACROS_SVH
// implication checked on every rising clock edge outside reset
`define VRT_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication checked outside reset
`define VRT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

// ===== rtl/core/vrt_pkg.sv =====
// package with types and constants of the voxel ray traversal block
package vrt_pkg;
    localparam logic [1:0] KIND_PROBE = 2'd0;
    localparam logic [1:0] KIND_HIT   = 2'd1;
    localparam logic [1:0] KIND_MISS  = 2'd2;
    localparam logic [0:0] OP_START   = 1'b0;
    localparam logic [0:0] OP_ANSWER  = 1'b1;
    localparam logic [31:0] DIST_MAX = 32'hFFFF_FFFF;
    localparam logic [7:0] DIST_LIMIT_RESET = 8'd10;

    // controller to datapath
    typedef struct packed {
        logic       load;       // capture origin/direction, clear axis counter
        logic       div_start;  // start one division
        logic       div_gap;    // 1 = gap division, 0 = first crossing
        logic       div_store;  // store quotient of current division
        logic       next_axis;  // advance setup axis
        logic       advance;    // step along least crossing axis
        logic       load_out;   // capture result into output register
        logic [1:0] out_kind;
    } vrt_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic div_done;
        logic last_axis;
        logic miss;
    } vrt_sts_t;
endpackage

// ===== rtl/core/vrt_divider.sv =====
// radix-2 restoring divider, one quotient bit per cycle
module vrt_divider (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [47:0] dividend,
    input  logic [15:0] divisor,
    output logic        done,
    output logic [47:0] quotient
);
    logic [47:0] quo_reg, quo_next;
    logic [16:0] rem_reg, rem_next;
    logic [15:0] dvs_reg, dvs_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [16:0] trial;
    logic [17:0] diff;

    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {rem_reg[15:0], quo_reg[47]};
        diff      = {1'b0, trial} - {2'b00, dvs_reg};
        if (start)
        begin
            quo_next  = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
            cnt_next  = 6'd48;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!diff[17])
            begin
                rem_next = diff[16:0];
                quo_next = {quo_reg[46:0], 1'b1};
            end
            else
            begin
                rem_next = trial;
                quo_next = {quo_reg[46:0], 1'b0};
            end
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;
endmodule

// ===== rtl/core/vrt_datapath.sv =====
// datapath: ray state, setup divisions, axis choice and output register
module vrt_datapath #(
    parameter int COORD_BITS    = 16,
    parameter int FRACTION_BITS = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  vrt_pkg::vrt_cmd_t   cmd,
    output vrt_pkg::vrt_sts_t   sts,
    input  logic [7:0]          dist_limit,
    input  logic [95:0]         origin,
    input  logic [47:0]         dir,
    output logic [49:0]         out_data
);
    localparam int SHL = 31 - FRACTION_BITS;

    logic [COORD_BITS-1:0] vox_reg [3];
    logic [2:0]            sgn_reg;
    logic [31:0]           nc_reg [3];
    logic [31:0]           gap_reg [3];
    logic [15:0]           mag_reg [3];
    logic [FRACTION_BITS-1:0] num_reg [3];
    logic [1:0]            ax_reg;
    logic [49:0]           out_reg;

    logic        div_done;
    logic [47:0] quotient, dividend;
    logic [31:0] qsat;
    logic [1:0]  sel;
    logic [32:0] sum;
    logic [15:0] mag_c [3];
    logic [31:0] o_c [3];
    logic [15:0] d_c [3];
    logic [COORD_BITS-1:0]    vox_c [3];
    logic [FRACTION_BITS-1:0] num_c [3];

    // per-axis setup values from the incoming start item
    always_comb
    begin
        for (int a = 0; a < 3; a++)
        begin
            o_c[a]   = origin[32*a +: 32];
            d_c[a]   = dir[16*a +: 16];
            mag_c[a] = d_c[a][15] ? (16'd0 - d_c[a]) : d_c[a];
            vox_c[a] = COORD_BITS'({{FRACTION_BITS{o_c[a][31]}},
                                    o_c[a][31:FRACTION_BITS]});
            if (d_c[a][15])
                num_c[a] = o_c[a][FRACTION_BITS-1:0];
            else if (o_c[a][FRACTION_BITS-1:0] == '0)
                num_c[a] = '0;
            else
                num_c[a] = FRACTION_BITS'(0) - o_c[a][FRACTION_BITS-1:0];
        end
    end

    always_comb
    begin
        dividend = cmd.div_gap ? (48'd1 << 31)
                               : ({{(48-FRACTION_BITS){1'b0}}, num_reg[ax_reg]} << SHL);
    end

    vrt_divider u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (dividend),
        .divisor  (mag_reg[ax_reg]),
        .done     (div_done),
        .quotient (quotient)
    );

    assign qsat = (|quotient[47:32]) ? vrt_pkg::DIST_MAX : quotient[31:0];

    always_comb
    begin
        if (nc_reg[0] < nc_reg[1])
            sel = (nc_reg[0] < nc_reg[2]) ? 2'd0 : 2'd2;
        else
            sel = (nc_reg[1] < nc_reg[2]) ? 2'd1 : 2'd2;
        sum = {1'b0, nc_reg[sel]} + {1'b0, gap_reg[sel]};
    end

    assign sts.div_done  = div_done;
    assign sts.last_axis = (ax_reg == 2'd2);
    assign sts.miss      = nc_reg[sel] > {8'd0, dist_limit, 16'd0};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ax_reg  <= '0;
            sgn_reg <= '0;
            for (int a = 0; a < 3; a++)
            begin
                vox_reg[a] <= '0;
                nc_reg[a]  <= '0;
                gap_reg[a] <= '0;
                mag_reg[a] <= '0;
                num_reg[a] <= '0;
            end
        end
        else
        begin
            if (cmd.load)
            begin
                ax_reg <= '0;
                for (int a = 0; a < 3; a++)
                begin
                    mag_reg[a] <= mag_c[a];
                    sgn_reg[a] <= d_c[a][15];
                    vox_reg[a] <= vox_c[a];
                    num_reg[a] <= num_c[a];
                    if (mag_c[a] == 16'd0)
                    begin
                        nc_reg[a]  <= vrt_pkg::DIST_MAX;
                        gap_reg[a] <= vrt_pkg::DIST_MAX;
                    end
                end
            end
            if (cmd.div_store && (mag_reg[ax_reg] != 16'd0))
            begin
                if (cmd.div_gap)
                    gap_reg[ax_reg] <= qsat;
                else
                    nc_reg[ax_reg] <= qsat;
            end
            if (cmd.next_axis)
                ax_reg <= ax_reg + 2'd1;
            if (cmd.advance)
            begin
                vox_reg[sel] <= sgn_reg[sel] ? vox_reg[sel] - COORD_BITS'(1)
                                             : vox_reg[sel] + COORD_BITS'(1);
                nc_reg[sel]  <= sum[32] ? vrt_pkg::DIST_MAX : sum[31:0];
            end
        end
    end

    // output register, voxel sign extended then cut to 16 bits
    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
            out_reg <= {16'(signed'(vox_reg[2])), 16'(signed'(vox_reg[1])),
                        16'(signed'(vox_reg[0])), cmd.out_kind};
    end

    assign out_data = out_reg;
endmodule

// ===== rtl/core/vrt_ctrl.sv =====
// controller state machine of the voxel walk
module vrt_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_fire,
    input  logic              op,
    input  logic              solid,
    input  logic              out_taken,
    output logic              in_ready,
    output logic              out_valid,
    output vrt_pkg::vrt_cmd_t cmd,
    input  vrt_pkg::vrt_sts_t sts
);
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_DIVNC = 3'd1;
    localparam logic [2:0] S_WNC   = 3'd2;
    localparam logic [2:0] S_DIVG  = 3'd3;
    localparam logic [2:0] S_WG    = 3'd4;
    localparam logic [2:0] S_ANS   = 3'd5;
    localparam logic [2:0] S_STEP  = 3'd6;

    logic [2:0] state_reg, state_next;
    logic       act_reg, act_next;
    logic       ov_reg, ov_next;
    logic       sol_reg, sol_next;

    assign in_ready  = (state_reg == S_IDLE) && !ov_reg;
    assign out_valid = ov_reg;

    always_comb
    begin
        state_next = state_reg;
        act_next   = act_reg;
        sol_next   = sol_reg;
        ov_next    = ov_reg && !out_taken;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
                if (in_fire)
                begin
                    if (op == vrt_pkg::OP_START)
                    begin
                        cmd.load   = 1'b1;
                        act_next   = 1'b1;
                        state_next = S_DIVNC;
                    end
                    else if (act_reg)
                    begin
                        sol_next   = solid;
                        state_next = S_ANS;
                    end
                end
            S_DIVNC:
            begin
                cmd.div_start = 1'b1;
                state_next    = S_WNC;
            end
            S_WNC:
                if (sts.div_done)
                begin
                    cmd.div_store = 1'b1;
                    state_next    = S_DIVG;
                end
            S_DIVG:
            begin
                cmd.div_start = 1'b1;
                cmd.div_gap   = 1'b1;
                state_next    = S_WG;
            end
            S_WG:
            begin
                cmd.div_gap = 1'b1;
                if (sts.div_done)
                begin
                    cmd.div_store = 1'b1;
                    if (sts.last_axis)
                    begin
                        cmd.load_out = 1'b1;
                        cmd.out_kind = vrt_pkg::KIND_PROBE;
                        ov_next      = 1'b1;
                        state_next   = S_IDLE;
                    end
                    else
                    begin
                        cmd.next_axis = 1'b1;
                        state_next    = S_DIVNC;
                    end
                end
            end
            S_ANS:
            begin
                if (sol_reg)
                begin
                    cmd.load_out = 1'b1;
                    cmd.out_kind = vrt_pkg::KIND_HIT;
                    act_next     = 1'b0;
                    ov_next      = 1'b1;
                end
                else if (sts.miss)
                begin
                    cmd.load_out = 1'b1;
                    cmd.out_kind = vrt_pkg::KIND_MISS;
                    act_next     = 1'b0;
                    ov_next      = 1'b1;
                end
                else
                begin
                    cmd.advance = 1'b1;
                end
                state_next = sol_reg || sts.miss ? S_IDLE : S_STEP;
            end
            S_STEP:
            begin
                // probe of the stepped voxel
                cmd.load_out = 1'b1;
                cmd.out_kind = vrt_pkg::KIND_PROBE;
                ov_next      = 1'b1;
                state_next   = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            act_reg   <= 1'b0;
            ov_reg    <= 1'b0;
            sol_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            act_reg   <= act_next;
            ov_reg    <= ov_next;
            sol_reg   <= sol_next;
        end
    end
endmodule

// ===== rtl/core/voxel_ray_traversal.sv =====
// top level of the voxel ray traversal block
// Amanatides-Woo 3d voxel walk. A start transfer (operation 0) takes a Q16.16
// origin and a Q1.15 unit direction and, after a setup of six serial divisions
// on the shared radix-2 divider, gives one probe transfer of the start voxel.
// Each answer transfer (operation 1) gives a hit, a miss or a probe of the
// next voxel; the walk accepts one item at a time and waits until its result
// transfer is taken. Answers with no ray in progress are dropped without
// a result.
module voxel_ray_traversal #(
    parameter int COORD_BITS    = 16,
    parameter int FRACTION_BITS = 16
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_we,
    input  logic [7:0]   cfg_wdata,
    input  logic         s_tvalid,
    output logic         s_tready,
    // origin_x, origin_y, origin_z, dir_x, dir_y, dir_z, solid, pad
    input  logic [151:0] s_tdata,
    // operation
    input  logic         s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // voxel_x, voxel_y, voxel_z
    output logic [47:0]  m_tdata,
    // kind
    output logic [1:0]   m_tuser
);
    logic              out_fire;
    logic              in_fire;
    logic [49:0]       out_data;
    vrt_pkg::vrt_cmd_t cmd;
    vrt_pkg::vrt_sts_t sts;
    logic [7:0]        max_dist_reg;

    // configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            max_dist_reg <= vrt_pkg::DIST_LIMIT_RESET;
        else if (cfg_we)
            max_dist_reg <= cfg_wdata;
    end

    assign in_fire  = s_tvalid && s_tready;
    assign out_fire = m_tvalid && m_tready;

    vrt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_fire   (in_fire),
        .op        (s_tuser),
        .solid     (s_tdata[144]),
        .out_taken (out_fire),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .cmd       (cmd),
        .sts       (sts)
    );

    vrt_datapath #(
        .COORD_BITS    (COORD_BITS),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sts          (sts),
        .dist_limit   (max_dist_reg),
        .origin       (s_tdata[95:0]),
        .dir          (s_tdata[143:96]),
        .out_data     (out_data)
    );

    // result kind travels on tuser, voxel coordinates on tdata
    assign m_tuser = out_data[1:0];
    assign m_tdata = out_data[49:2];

`include "voxel_ray_traversal_macros.svh"

    `VRT_ASSERT_IMP(a_no_accept_busy, m_tvalid, !s_tready, "input taken while result pending")
    `VRT_ASSERT_IMP(a_kind_legal, m_tvalid, m_tuser != 2'd3, "illegal result kind")
    `VRT_ASSERT_NEXT(a_div_cmd, cmd.div_start, !cmd.div_start, "divider restarted back to back")
endmodule

// ===== verif/tb_voxel_ray_traversal.sv =====
// self-checking testbench of the voxel ray traversal block
module tb_voxel_ray_traversal;
    timeunit 1ns;
    timeprecision 1ps;

    // one input transfer, unpacked
    typedef struct {
        logic [0:0]  op;
        logic [31:0] org [3];
        logic [15:0] dir [3];
        logic        solid;
    } ray_item_t;

    // predicted walk state plus queue of expected result transfers
    class ray_walk_board;
        logic [7:0]  max_dist;
        logic [15:0] voxel [3];
        logic        step_neg [3];
        logic [31:0] cross_at [3];
        logic [31:0] cross_step [3];
        logic        walking;
        logic [49:0] pending [$];
        int          errors;
        int          hits;
        int          misses;
        int          probes;

        function new();
            max_dist = vrt_pkg::DIST_LIMIT_RESET;
            walking  = 1'b0;
            errors   = 0;
            hits     = 0;
            misses   = 0;
            probes   = 0;
            for (int a = 0; a < 3; a++)
            begin
                voxel[a]      = '0;
                step_neg[a]   = 1'b0;
                cross_at[a]   = '0;
                cross_step[a] = '0;
            end
        endfunction

        function void push_result(logic [1:0] kind);
            pending.push_back({voxel[2], voxel[1], voxel[0], kind});
        endfunction

        function void setup_axis(int a, logic [31:0] o, logic [15:0] d);
            logic [63:0] frac;
            logic [63:0] mag;
            logic [63:0] num;
            logic [63:0] t;
            frac        = {48'd0, o[15:0]};
            voxel[a]    = o[31:16];
            step_neg[a] = d[15];
            mag         = d[15] ? {48'd0, 16'(-d)} : {48'd0, d};
            if (d[15] && mag == 0)
                mag = 64'h8000;
            if (mag == 0)
            begin
                cross_at[a]   = vrt_pkg::DIST_MAX;
                cross_step[a] = vrt_pkg::DIST_MAX;
                return;
            end
            if (d[15])
                num = frac;
            else
                num = (frac == 0) ? 64'd0 : (64'h10000 - frac);
            t = (num << 15) / mag;
            cross_at[a] = (t > 64'hFFFF_FFFF) ? vrt_pkg::DIST_MAX : t[31:0];
            t = (64'd1 << 31) / mag;
            cross_step[a] = (t > 64'hFFFF_FFFF) ? vrt_pkg::DIST_MAX : t[31:0];
        endfunction

        // works out the result of one accepted input transfer
        function void note_transfer(ray_item_t it);
            int          ax;
            logic [32:0] sum;
            if (it.op == vrt_pkg::OP_START)
            begin
                for (int a = 0; a < 3; a++)
                    setup_axis(a, it.org[a], it.dir[a]);
                walking = 1'b1;
                push_result(vrt_pkg::KIND_PROBE);
                return;
            end
            if (!walking)
                return;
            if (it.solid)
            begin
                walking = 1'b0;
                push_result(vrt_pkg::KIND_HIT);
                return;
            end
            if (cross_at[0] < cross_at[1])
                ax = (cross_at[0] < cross_at[2]) ? 0 : 2;
            else
                ax = (cross_at[1] < cross_at[2]) ? 1 : 2;
            if (cross_at[ax] > {8'd0, max_dist, 16'd0})
            begin
                walking = 1'b0;
                push_result(vrt_pkg::KIND_MISS);
                return;
            end
            voxel[ax] = step_neg[ax] ? voxel[ax] - 16'd1 : voxel[ax] + 16'd1;
            sum = {1'b0, cross_at[ax]} + {1'b0, cross_step[ax]};
            cross_at[ax] = sum[32] ? vrt_pkg::DIST_MAX : sum[31:0];
            push_result(vrt_pkg::KIND_PROBE);
        endfunction

        // compares one result transfer with the oldest expectation
        function void check_transfer(logic [49:0] got);
            logic [49:0] want;
            if (pending.size() == 0)
            begin
                $error("unexpected result transfer %h", got);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (want[1:0] == vrt_pkg::KIND_HIT)
                hits++;
            else if (want[1:0] == vrt_pkg::KIND_MISS)
                misses++;
            else
                probes++;
            if (got[1:0] !== want[1:0])
            begin
                $error("kind: expected %0d actual %0d", want[1:0], got[1:0]);
                errors++;
            end
            if (got[17:2] !== want[17:2])
            begin
                $error("voxel_x: expected %h actual %h", want[17:2], got[17:2]);
                errors++;
            end
            if (got[33:18] !== want[33:18])
            begin
                $error("voxel_y: expected %h actual %h", want[33:18], got[33:18]);
                errors++;
            end
            if (got[49:34] !== want[49:34])
            begin
                $error("voxel_z: expected %h actual %h", want[49:34], got[49:34]);
                errors++;
            end
        endfunction
    endclass

    logic         clk;
    logic         rst_n;
    logic         cfg_we;
    logic [7:0]   cfg_wdata;
    logic         s_tvalid;
    logic         s_tready;
    // origin_x, origin_y, origin_z, dir_x, dir_y, dir_z, solid, pad
    logic [151:0] s_tdata;
    // operation
    logic         s_tuser;
    logic         m_tvalid;
    logic         m_tready;
    // voxel_x, voxel_y, voxel_z
    logic [47:0]  m_tdata;
    // kind
    logic [1:0]   m_tuser;

    ray_walk_board board;
    int  cycles = 0;
    int  sent;
    bit  no_idle;  // phases with back-to-back transfers on both sides
    localparam int CYCLE_LIMIT = 3000000;

    voxel_ray_traversal DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    // 4 ns clock
    initial
    begin
        clk = 1'b0;
    end
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // watchdog on the whole run
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("FAIL voxel_ray_traversal");
            $finish;
        end
    end

    // send one input transfer, hold valid until taken, then maybe idle
    task automatic send_item(ray_item_t it);
        int gap;
        s_tvalid <= 1'b1;
        s_tdata  <= {7'd0, it.solid, it.dir[2], it.dir[1], it.dir[0],
                     it.org[2], it.org[1], it.org[0]};
        s_tuser  <= it.op;
        do
            @(posedge clk);
        while (!s_tready);
        board.note_transfer(it);
        sent++;
        gap = no_idle ? 0 : $urandom_range(13);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    function automatic ray_item_t start_item(logic [31:0] ox, logic [31:0] oy,
                                             logic [31:0] oz, logic [15:0] dx,
                                             logic [15:0] dy, logic [15:0] dz);
        ray_item_t it;
        it.op     = vrt_pkg::OP_START;
        it.org[0] = ox;
        it.org[1] = oy;
        it.org[2] = oz;
        it.dir[0] = dx;
        it.dir[1] = dy;
        it.dir[2] = dz;
        it.solid  = 1'($urandom_range(1));
        return it;
    endfunction

    // answer transfer, origin and direction bits carry junk
    function automatic ray_item_t answer_item(logic solid);
        ray_item_t it;
        it.op    = vrt_pkg::OP_ANSWER;
        it.solid = solid;
        for (int a = 0; a < 3; a++)
        begin
            it.org[a] = $urandom;
            it.dir[a] = 16'($urandom);
        end
        return it;
    endfunction

    function automatic logic [15:0] rand_dir();
        case ($urandom_range(7))
            0: return 16'h0000;
            1: return 16'h8000;
            2: return 16'h7FFF;
            3: return 16'(-$urandom_range(32767));
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [31:0] rand_origin();
        if ($urandom_range(3) == 0)
            return $urandom;
        // near zero, with a random fraction and an occasional whole-cell origin
        return {16'($signed($urandom_range(40)) - 16'sd20),
                ($urandom_range(4) == 0) ? 16'd0 : 16'($urandom)};
    endfunction

    // idle until every expected result is in, then let the block settle
    task automatic drain();
        s_tvalid <= 1'b0;
        while (board.pending.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    task automatic write_dist_limit(logic [7:0] v);
        drain();
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we    <= 1'b0;
        board.max_dist = v;
    endtask

    // one ray: start and answers until it ends, with some broken sequences
    task automatic random_ray();
        int cap;
        int n;
        send_item(start_item(rand_origin(), rand_origin(), rand_origin(),
                             rand_dir(), rand_dir(), rand_dir()));
        cap = $urandom_range(80, 1);
        n   = 0;
        while (board.walking && n < cap)
        begin
            send_item(answer_item($urandom_range(24) == 0));
            n++;
        end
        // stray answer after the ray has ended
        if ($urandom_range(9) == 0)
            send_item(answer_item(1'($urandom_range(1))));
    endtask

    // result side: random stall before every result transfer, none in the no-idle phase
    initial
    begin
        int gap;
        m_tready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            gap = no_idle ? 0 : $urandom_range(13);
            if (gap > 0)
            begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            m_tready <= 1'b1;
            do
                @(posedge clk);
            while (!m_tvalid);
            board.check_transfer({m_tdata, m_tuser});
        end
    end

    initial
    begin
        logic [7:0] settings [6];
        board     = new();
        sent      = 0;
        no_idle   = 1'b0;
        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_wdata = '0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: answers with no ray are dropped
        send_item(answer_item(1'b0));
        send_item(answer_item(1'b1));
        // extreme origins, zero and extreme directions
        send_item(start_item(32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000,
                             16'h0000, 16'h0000, 16'h0000));
        send_item(answer_item(1'b0));
        send_item(start_item(32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF,
                             16'h7FFF, 16'h8000, 16'h0000));
        repeat (4) send_item(answer_item(1'b0));
        send_item(answer_item(1'b1));
        // ties between axes on whole-cell origins
        send_item(start_item(32'h0001_0000, 32'h0002_0000, 32'h0003_0000,
                             16'h4000, 16'h4000, 16'h4000));
        repeat (5) send_item(answer_item(1'b0));
        // restart during an active ray
        send_item(start_item(32'h0000_8000, 32'hFFFF_8000, 32'h0000_0001,
                             16'hC000, 16'h2000, 16'hE000));
        repeat (4) send_item(answer_item(1'b0));
        send_item(answer_item(1'b1));
        // coordinate wrap at the top of the voxel range
        send_item(start_item(32'h7FFF_C000, 32'h8000_4000, 32'h0000_0000,
                             16'h7FFF, 16'h0000, 16'h0000));
        repeat (3) send_item(answer_item(1'b0));

        settings[0] = vrt_pkg::DIST_LIMIT_RESET;
        settings[1] = 8'd1;
        settings[2] = 8'd255;
        settings[3] = 8'($urandom_range(255, 1));
        settings[4] = 8'($urandom_range(20, 2));
        settings[5] = 8'($urandom_range(255, 1));
        for (int p = 0; p < 6; p++)
        begin
            if (p > 0)
                write_dist_limit(settings[p]);
            no_idle = (p == 4);
            while (sent < 25 + (p + 1) * 155)
                random_ray();
        end

        drain();
        repeat (20) @(posedge clk);
        $display("run covered %0d input transfers over 6 distance limits", sent);
        $display("results: %0d probes, %0d hits, %0d misses",
                 board.probes, board.hits, board.misses);
        if (board.errors == 0 && board.pending.size() == 0)
            $display("PASS voxel_ray_traversal");
        else
            $display("FAIL voxel_ray_traversal");
        $finish;
    end
endmodule
